@@ design/pip_pkg.sv @@
// Package for the point-in-polygon test: sizes, register indexes, reset
// vertices and the stage-enable struct shared by the top level and edge lanes.
// Depends on nothing.
`default_nettype none

package pip_pkg;

    // Polygon size and vertex coordinate width (whole pixels)
    localparam int MAX_VERTICES = 6;
    localparam int COORD_BITS   = 12;

    // Query point width (quarter pixels), fixed by the input fields
    localparam int PT_W     = 14;
    // One vertex register: x in the low half, y in the high half
    localparam int VERT_W   = 2 * COORD_BITS;
    // Vertex coordinate scaled to quarter pixels
    localparam int X4_W     = COORD_BITS + 2;
    // Signed difference of two quarter-pixel coordinates
    localparam int DIFF_W   = ((X4_W > PT_W) ? X4_W : PT_W) + 1;
    // Exact product of two differences
    localparam int PROD_W   = 2 * DIFF_W;
    // Vertex index and vertex count
    localparam int IDX_W    = $clog2(MAX_VERTICES);
    localparam int CNT_W    = 3;
    // Configuration port
    localparam int CFG_IDX_W  = $clog2(MAX_VERTICES + 1);
    localparam int CFG_DATA_W = (VERT_W > CNT_W) ? VERT_W : CNT_W;
    // Stream data widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 8;

    // Register indexes
    localparam int REG_VERTEX_COUNT = 0;
    localparam int REG_VERTEX_BASE  = 1;

    // Smallest polygon
    localparam int MIN_VERTICES = 3;

    // Reset polygon, whole pixels
    localparam int RESET_COUNT = 6;
    localparam int RESET_X [6] = '{77, 862, 746, 752, 234, 232};
    localparam int RESET_Y [6] = '{141, 141, 444, 512, 512, 444};

    typedef logic [VERT_W-1:0] t_vertex;

    // Per-stage advance enables of the pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pip_en;

    // Reset value of vertex register k
    function automatic t_vertex reset_vertex(input int k);
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        if (k < 6) begin
            x = COORD_BITS'(RESET_X[k]);
            y = COORD_BITS'(RESET_Y[k]);
        end else begin
            x = '0;
            y = '0;
        end
        return {y, x};
    endfunction

endpackage

`default_nettype wire

@@ design/pip_edge.sv @@
// One edge lane of the point-in-polygon test: straddle check, exact
// cross-multiplied crossing test, and the lane's toggle bit over three stages.
// Depends on pip_pkg.
`default_nettype none

module pip_edge
    import pip_pkg::*;
(
    input  wire               i_clk,
    input  t_pip_en           i_en,
    input  wire  [PT_W-1:0]   i_px,
    input  wire  [PT_W-1:0]   i_py,
    input  t_vertex           i_vi,
    input  t_vertex           i_vj,
    input  wire               i_active,
    output logic              o_toggle
);

    logic [X4_W-1:0] xi4, yi4, xj4, yj4;

    // Stage 1 registers: differences and straddle flag
    logic                     r_straddle, n_straddle;
    logic signed [DIFF_W-1:0] r_dy, n_dy;
    logic signed [DIFF_W-1:0] r_dxp, n_dxp;
    logic signed [DIFF_W-1:0] r_dxe, n_dxe;
    logic signed [DIFF_W-1:0] r_dpy, n_dpy;

    // Stage 2 registers: products
    logic                     r_str2;
    logic                     r_up;
    logic signed [PROD_W-1:0] r_lhs, n_lhs;
    logic signed [PROD_W-1:0] r_rhs, n_rhs;

    // Stage 3 register: lane toggle
    logic r_toggle, n_toggle;

    // Scale vertices to quarter pixels
    assign xi4 = {i_vi[COORD_BITS-1:0], 2'b00};
    assign yi4 = {i_vi[VERT_W-1:COORD_BITS], 2'b00};
    assign xj4 = {i_vj[COORD_BITS-1:0], 2'b00};
    assign yj4 = {i_vj[VERT_W-1:COORD_BITS], 2'b00};

    // Straddle test and differences
    always_comb begin
        n_straddle = i_active &&
                     ((DIFF_W'(yi4) > DIFF_W'(i_py)) != (DIFF_W'(yj4) > DIFF_W'(i_py)));
        n_dy  = $signed(DIFF_W'(yj4)) - $signed(DIFF_W'(yi4));
        n_dxp = $signed(DIFF_W'(i_px)) - $signed(DIFF_W'(xi4));
        n_dxe = $signed(DIFF_W'(xj4)) - $signed(DIFF_W'(xi4));
        n_dpy = $signed(DIFF_W'(i_py)) - $signed(DIFF_W'(yi4));
    end

    // Exact cross products
    always_comb begin
        n_lhs = PROD_W'(r_dxp) * PROD_W'(r_dy);
        n_rhs = PROD_W'(r_dxe) * PROD_W'(r_dpy);
    end

    // Crossing lies right of the point; inequality flips for downward edges
    always_comb begin
        if (r_up) begin
            n_toggle = r_str2 && (r_lhs < r_rhs);
        end else begin
            n_toggle = r_str2 && (r_lhs > r_rhs);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_straddle <= n_straddle;
            r_dy       <= n_dy;
            r_dxp      <= n_dxp;
            r_dxe      <= n_dxe;
            r_dpy      <= n_dpy;
        end
        if (i_en.s2) begin
            r_str2 <= r_straddle;
            r_up   <= (r_dy > 0);
            r_lhs  <= n_lhs;
            r_rhs  <= n_rhs;
        end
        if (i_en.s3) begin
            r_toggle <= n_toggle;
        end
    end

    assign o_toggle = r_toggle;

endmodule

`default_nettype wire

@@ design/point_in_polygon_test.sv @@
// Point-in-polygon test, even-odd ray casting over up to six vertices.
// One registered stage each for the differences, the cross products, and the
// compare, with the parity taken at the output.
// Throughput: one item per cycle; empty stages fill while a result waits, and
// the input is refused only when all three stages are full and the output stalls.
// Reset (synchronous, active low) empties the pipeline and loads the default polygon.
`default_nettype none

module point_in_polygon_test
    import pip_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Configuration write port
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]  i_cfg_data,
    // Input stream
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [IN_DATA_W-1:0]   s_axis_tdata,  // [13:0] point_x, [27:14] point_y
    // Output stream
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata   // [0] inside_res
);

    // Configuration registers
    logic [CNT_W-1:0] r_vertex_count;
    t_vertex          r_vertex [MAX_VERTICES];

    // Stage valid bits
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;

    t_pip_en           en;
    logic              s_accept;
    logic [PT_W-1:0]   px, py;
    logic [CNT_W-1:0]  n_cnt;
    logic [IDX_W-1:0]  last_idx;
    t_vertex           vj [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] active;
    logic [MAX_VERTICES-1:0] toggles;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= CNT_W'(RESET_COUNT);
            for (int k = 0; k < MAX_VERTICES; k++) begin
                r_vertex[k] <= reset_vertex(k);
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_IDX_W'(REG_VERTEX_COUNT)) begin
                r_vertex_count <= i_cfg_data[CNT_W-1:0];
            end
            for (int k = 0; k < MAX_VERTICES; k++) begin
                if (i_cfg_index == CFG_IDX_W'(REG_VERTEX_BASE + k)) begin
                    r_vertex[k] <= i_cfg_data[VERT_W-1:0];
                end
            end
        end
    end

    // Stage enables: a stage moves when it is empty or its successor moves
    always_comb begin
        en.s3 = !r_v3 || m_axis_tready;
        en.s2 = !r_v2 || en.s3;
        en.s1 = !r_v1 || en.s2;
    end

    assign s_axis_tready = en.s1;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Valid bits follow the data
    always_comb begin
        n_v1 = en.s1 ? s_accept : r_v1;
        n_v2 = en.s2 ? r_v1     : r_v2;
        n_v3 = en.s3 ? r_v2     : r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    assign px = s_axis_tdata[PT_W-1:0];
    assign py = s_axis_tdata[2*PT_W-1:PT_W];

    // Clamp vertex count to the supported range
    always_comb begin
        if (r_vertex_count < CNT_W'(MIN_VERTICES)) begin
            n_cnt = CNT_W'(MIN_VERTICES);
        end else if (r_vertex_count > CNT_W'(MAX_VERTICES)) begin
            n_cnt = CNT_W'(MAX_VERTICES);
        end else begin
            n_cnt = r_vertex_count;
        end
    end

    assign last_idx = IDX_W'(n_cnt - CNT_W'(1));

    // Edge k runs from vertex k-1 to vertex k; edge 0 closes from the last vertex
    always_comb begin
        vj[0] = r_vertex[last_idx];
        for (int k = 1; k < MAX_VERTICES; k++) begin
            vj[k] = r_vertex[k-1];
        end
        for (int k = 0; k < MAX_VERTICES; k++) begin
            active[k] = (CNT_W'(k) < n_cnt);
        end
    end

    for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_edge
        pip_edge u_edge (
            .i_clk    (i_clk),
            .i_en     (en),
            .i_px     (px),
            .i_py     (py),
            .i_vi     (r_vertex[g]),
            .i_vj     (vj[g]),
            .i_active (active[g]),
            .o_toggle (toggles[g])
        );
    end

    // Even-odd parity of the crossings
    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {(OUT_DATA_W-1)'(0), ^toggles};

    // A full pipeline is the only reason to refuse input
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input refused while a stage is empty");

    // An item in stage 2 moves into stage 3 when stage 3 advances
    a_s2_to_s3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en.s3) |=> r_v3)
        else $error("item lost between stage 2 and stage 3");

    // A blocked stage-1 item is kept
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !en.s2) |=> r_v1)
        else $error("blocked stage 1 item dropped");

    // Clamped vertex count stays within the polygon limits
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_cnt >= CNT_W'(MIN_VERTICES)) && (n_cnt <= CNT_W'(MAX_VERTICES)))
        else $error("vertex count out of range after clamp");

endmodule

`default_nettype wire
